// ===== rtl/paletted_texture_texel_fetch_macros.svh =====
// Assertion helpers shared by the texel fetch RTL.
// Both expect signals named clock and reset in the enclosing module.
`ifndef PALETTED_TEXTURE_TEXEL_FETCH_MACROS_SVH
`define PALETTED_TEXTURE_TEXEL_FETCH_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define PTTF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define PTTF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pttf_pkg.sv =====
package pttf_pkg;

   // Memory geometry
   localparam int unsigned MEMORY_WIDTH_WORDS  = 1024;
   localparam int unsigned MEMORY_ROWS_DEFAULT = 1536;
   localparam int unsigned COL_W   = $clog2(MEMORY_WIDTH_WORDS);
   localparam int unsigned ROW_W   = 11;
   localparam int unsigned ADDR_W  = 21;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned COORD_W = 8;
   localparam int unsigned INDEX_W = 8;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_PAGE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE      = 1'b1;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   // Colour modes (any other code is direct 15-bit)
   localparam logic [1:0] MODE_4BIT = 2'd0;
   localparam logic [1:0] MODE_8BIT = 2'd1;

endpackage

// ===== rtl/paletted_texture_texel_fetch.sv =====
// Paletted texel fetch over a 16-bit video memory, 1024 words per row.
// Input channel (req_*): one word per accepted item. A write item stores
// req_write_data at req_word_address and gives no result; a fetch item
// reads the texel at req_tex_u, req_tex_v in the texture page set by the
// texture page register, and in the 4-bit and 8-bit modes looks the
// unpacked index up in the palette set by the palette register.
// Result channel (rsp_*): one word per fetch, in input order.
// Configuration (csr_*): register 0 texture page, register 1 palette;
// write only while no item is in flight.
// Throughput: one item per cycle unless rsp_stall backs up the pipe; the texel
// read and the palette read use two read ports of the memory, one pipeline
// stage each.
// Reset clears the valid bits and both registers; memory contents are
// undefined until written. While rsp_stall holds a result, the internal
// stages keep taking items until they are full; writes drain regardless.
module paletted_texture_texel_fetch import pttf_pkg::*; #(
   parameter int unsigned MEMORY_ROWS = MEMORY_ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [ADDR_W-1:0]      req_word_address,
   input  logic [WORD_W-1:0]      req_write_data,
   input  logic [COORD_W-1:0]     req_tex_u,
   input  logic [COORD_W-1:0]     req_tex_v,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_W-1:0]      rsp_texel_color,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_write_data
);

   localparam int unsigned MemWords = MEMORY_ROWS * MEMORY_WIDTH_WORDS;
   localparam int unsigned MemAw    = $clog2(MemWords);
   localparam logic [ADDR_W:0] MemLimit = (ADDR_W+1)'(MemWords);

   logic [WORD_W-1:0] video_mem [MemWords];

   logic [WORD_W-1:0] tpage_ff;
   logic [WORD_W-1:0] palette_ff;

   // Stage ready chain
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

   // Stage 1: captured input word
   logic               s1_valid_ff;
   logic               s1_kind_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [WORD_W-1:0]  s1_data_ff;
   logic [COORD_W-1:0] s1_u_ff;
   logic [COORD_W-1:0] s1_v_ff;

   // Stage 2: resolved memory address
   logic               s2_valid_ff;
   logic               s2_kind_ff;
   logic [ADDR_W-1:0]  s2_addr_ff;
   logic               s2_inr_ff;
   logic [WORD_W-1:0]  s2_data_ff;
   logic [1:0]         s2_mode_ff;
   logic [1:0]         s2_usel_ff;

   // Stage 3: texel word read
   logic               s3_valid_ff;
   logic               s3_kind_ff;
   logic [ADDR_W-1:0]  s3_addr_ff;
   logic               s3_inr_ff;
   logic [WORD_W-1:0]  s3_data_ff;
   logic [1:0]         s3_mode_ff;
   logic [1:0]         s3_usel_ff;
   logic               s3_fwd_hit_ff;
   logic [WORD_W-1:0]  s3_fwd_data_ff;
   logic [WORD_W-1:0]  s3_rd_ff;

   // Stage 4: palette word read
   logic               s4_valid_ff;
   logic               s4_kind_ff;
   logic [ADDR_W-1:0]  s4_addr_ff;
   logic               s4_inr_ff;
   logic [WORD_W-1:0]  s4_data_ff;
   logic               s4_direct_ff;
   logic [WORD_W-1:0]  s4_word_ff;
   logic               s4_pal_inr_ff;
   logic               s4_fwd_hit_ff;
   logic [WORD_W-1:0]  s4_fwd_data_ff;
   logic [WORD_W-1:0]  s4_rd_ff;

   // Stage 5: result register
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_color_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tpage_ff   <= '0;
         palette_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TEXTURE_PAGE: tpage_ff   <= csr_write_data;
            CSR_PALETTE:      palette_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or its word moves on; writes leave stage 4
   assign s5_ready  = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || (s4_kind_ff == KIND_WRITE) || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_ready) begin
            rsp_valid_ff <= s4_valid_ff && (s4_kind_ff == KIND_FETCH);
         end
      end
   end

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_kind_ff <= req_kind;
         s1_addr_ff <= req_word_address;
         s1_data_ff <= req_write_data;
         s1_u_ff    <= req_tex_u;
         s1_v_ff    <= req_tex_v;
      end
   end

   // Stage 1: page origin and texel address
   logic [1:0]         s1_mode;
   logic [5:0]         s1_ext;
   logic [5:0]         s1_ext_m1;
   logic [COL_W-1:0]   s1_page_x;
   logic [ROW_W-1:0]   s1_page_y;
   logic [COORD_W-1:0] s1_u_off;
   logic [ROW_W-1:0]   s1_col;
   logic [ROW_W-1:0]   s1_row;
   logic [ADDR_W-1:0]  s1_tex_addr;
   logic [ADDR_W-1:0]  s2_addr_in;
   logic               s2_inr_in;

   always_comb begin
      s1_mode   = tpage_ff[8:7];
      s1_ext    = tpage_ff[15:10];
      s1_ext_m1 = s1_ext - 6'd1;
      if (s1_ext != 6'd0) begin
         s1_page_x = {s1_ext_m1[3:0], 6'd0};
         s1_page_y = {({1'b0, s1_ext_m1[5:4]} + 3'd2), 8'd0};
      end else begin
         s1_page_x = {tpage_ff[3:0], 6'd0};
         s1_page_y = {2'd0, tpage_ff[4], 8'd0};
      end
      case (s1_mode)
         MODE_4BIT: s1_u_off = {2'd0, s1_u_ff[7:2]};
         MODE_8BIT: s1_u_off = {1'b0, s1_u_ff[7:1]};
         default:   s1_u_off = {2'd0, s1_u_ff[5:0]};
      endcase
      s1_col      = {1'b0, s1_page_x} + {3'd0, s1_u_off};
      s1_row      = s1_page_y + {3'd0, s1_v_ff};
      s1_tex_addr = {s1_row, {COL_W{1'b0}}} + ADDR_W'(s1_col);
      s2_addr_in  = (s1_kind_ff == KIND_WRITE) ? s1_addr_ff : s1_tex_addr;
      s2_inr_in   = ({1'b0, s2_addr_in} < MemLimit);
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_kind_ff <= s1_kind_ff;
         s2_addr_ff <= s2_addr_in;
         s2_inr_ff  <= s2_inr_in;
         s2_data_ff <= s1_data_ff;
         s2_mode_ff <= s1_mode;
         s2_usel_ff <= s1_u_ff[1:0];
      end
   end

   // Stage 2: forward older writes still ahead in the pipe, younger first
   logic s2_hit3, s2_hit4;

   always_comb begin
      s2_hit3 = s3_valid_ff && (s3_kind_ff == KIND_WRITE) && s3_inr_ff
                && (s3_addr_ff == s2_addr_ff);
      s2_hit4 = s4_valid_ff && (s4_kind_ff == KIND_WRITE) && s4_inr_ff
                && (s4_addr_ff == s2_addr_ff);
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_kind_ff     <= s2_kind_ff;
         s3_addr_ff     <= s2_addr_ff;
         s3_inr_ff      <= s2_inr_ff;
         s3_data_ff     <= s2_data_ff;
         s3_mode_ff     <= s2_mode_ff;
         s3_usel_ff     <= s2_usel_ff;
         s3_fwd_hit_ff  <= s2_hit3 || s2_hit4;
         s3_fwd_data_ff <= s2_hit3 ? s3_data_ff : s4_data_ff;
      end
   end

   // Stage 3: unpack the palette index and locate the palette word
   logic [WORD_W-1:0]  s3_word;
   logic [INDEX_W-1:0] s3_index;
   logic [ROW_W-1:0]   s3_pal_off;
   logic [ADDR_W-1:0]  s3_pal_addr;
   logic               s3_pal_inr;
   logic               s3_pal_hit;
   logic               s3_direct;

   always_comb begin
      if (!s3_inr_ff) begin
         s3_word = '0;
      end else if (s3_fwd_hit_ff) begin
         s3_word = s3_fwd_data_ff;
      end else begin
         s3_word = s3_rd_ff;
      end
      s3_direct = 1'b0;
      case (s3_mode_ff)
         MODE_4BIT: s3_index = {4'd0, s3_word[4*s3_usel_ff +: 4]};
         MODE_8BIT: s3_index = s3_word[8*s3_usel_ff[0] +: 8];
         default: begin
            s3_index  = '0;
            s3_direct = 1'b1;
         end
      endcase
      s3_pal_off  = {1'b0, palette_ff[5:0], 4'd0} + {3'd0, s3_index};
      s3_pal_addr = {1'b0, palette_ff[15:6], {COL_W{1'b0}}} + ADDR_W'(s3_pal_off);
      s3_pal_inr  = ({1'b0, s3_pal_addr} < MemLimit);
      s3_pal_hit  = s4_valid_ff && (s4_kind_ff == KIND_WRITE) && s4_inr_ff
                    && (s4_addr_ff == s3_pal_addr);
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_kind_ff     <= s3_kind_ff;
         s4_addr_ff     <= s3_addr_ff;
         s4_inr_ff      <= s3_inr_ff;
         s4_data_ff     <= s3_data_ff;
         s4_direct_ff   <= s3_direct;
         s4_word_ff     <= s3_word;
         s4_pal_inr_ff  <= s3_pal_inr;
         s4_fwd_hit_ff  <= s3_pal_hit;
         s4_fwd_data_ff <= s4_data_ff;
      end
   end

   // Video memory: one write port, texel and palette read ports
   always_ff @(posedge clock) begin
      if (s4_valid_ff && (s4_kind_ff == KIND_WRITE) && s4_inr_ff) begin
         video_mem[s4_addr_ff[MemAw-1:0]] <= s4_data_ff;
      end
      if (s3_ready) begin
         s3_rd_ff <= video_mem[s2_addr_ff[MemAw-1:0]];
      end
      if (s4_ready) begin
         s4_rd_ff <= video_mem[s3_pal_addr[MemAw-1:0]];
      end
   end

   // Stage 4: select the colour
   logic [WORD_W-1:0] s4_color;

   always_comb begin
      if (s4_direct_ff) begin
         s4_color = s4_word_ff;
      end else if (!s4_pal_inr_ff) begin
         s4_color = '0;
      end else if (s4_fwd_hit_ff) begin
         s4_color = s4_fwd_data_ff;
      end else begin
         s4_color = s4_rd_ff;
      end
   end

   // Stage 5: hold the result while stalled
   always_ff @(posedge clock) begin
      if (s5_ready) begin
         rsp_color_ff <= s4_color;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_texel_color = rsp_color_ff;

`include "paletted_texture_texel_fetch_macros.svh"

   `PTTF_ASSERT_NOW(a_write_retires, s4_valid_ff && (s4_kind_ff == KIND_WRITE), s4_ready, "write held in stage 4")
   `PTTF_ASSERT_NOW(a_full_stalls, rsp_valid_ff && rsp_stall && s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && (s4_kind_ff == KIND_FETCH), req_stall, "full pipe took a word")
   `PTTF_ASSERT_NEXT(a_accept_fills, req_valid && !req_stall, s1_valid_ff, "accepted word lost at stage 1")

endmodule
